// ===== src/hlfr_pkg.sv =====
// hlfr_pkg: shared constants for the header/length frame receiver
// parse phase codes, register indexes and field widths
// no dependencies
package hlfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W = 2;

    // parse phase codes
    localparam logic [PHASE_W-1:0] PHASE_HDR1 = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_HDR2 = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_CMD  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_LEN  = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_BODY = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_CMD_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_CMD_B   = 2'd3;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd201;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd218;
    localparam logic [BYTE_W-1:0] SHORT_CMD_A_RST   = 8'd163;
    localparam logic [BYTE_W-1:0] SHORT_CMD_B_RST   = 8'd164;

    // two crc bytes close every frame
    localparam logic [POS_W-1:0] CRC_BYTES = 9'd2;

endpackage

// ===== src/header_length_frame_receiver_top.sv =====
// output: an accepted byte is registered and shows on the output in the cycle after it is accepted
// throughput: one byte per cycle; the output register frees as it is taken,
//   so a new byte is accepted whenever the output is empty or the held word leaves in the same cycle
// reset (rst_n low, asynchronous): parser hunts the first header, counters
//   clear, registers return to their defaults, output empty
// header_length_frame_receiver_top: frame parser with output register
// depends on hlfr_pkg
module header_length_frame_receiver_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [hlfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hlfr_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hlfr_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hlfr_pkg::BYTE_W-1:0]  data_byte,
    output logic [hlfr_pkg::POS_W-1:0]   position,
    output logic                         last
);
    import hlfr_pkg::*;

    logic [BYTE_W-1:0]  header_first_reg;
    logic [BYTE_W-1:0]  header_second_reg;
    logic [BYTE_W-1:0]  short_cmd_a_reg;
    logic [BYTE_W-1:0]  short_cmd_b_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [POS_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]   next_pos_reg, next_pos_next;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  data_byte_reg;
    logic [POS_W-1:0]   position_reg;
    logic               last_reg;

    logic               emit;
    logic [POS_W-1:0]   emit_pos;
    logic               emit_last;
    logic               in_accept;
    logic               fin;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign fin       = (bytes_left_reg <= POS_W'(1));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            short_cmd_a_reg   <= SHORT_CMD_A_RST;
            short_cmd_b_reg   <= SHORT_CMD_B_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                REG_HEADER_SECOND: header_second_reg <= cfg_data;
                REG_SHORT_CMD_A:   short_cmd_a_reg   <= cfg_data;
                REG_SHORT_CMD_B:   short_cmd_b_reg   <= cfg_data;
            endcase
        end
    end

    // parser next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        next_pos_next   = next_pos_reg;
        emit            = 1'b0;
        emit_pos        = '0;
        emit_last       = 1'b0;
        unique case (phase_reg)
            PHASE_HDR2:
            begin
                phase_next = (rx_byte == header_second_reg) ? PHASE_CMD : PHASE_HDR1;
            end
            PHASE_CMD:
            begin
                emit = 1'b1;
                if (rx_byte == short_cmd_a_reg || rx_byte == short_cmd_b_reg)
                begin
                    bytes_left_next = CRC_BYTES;
                    next_pos_next   = POS_W'(1);
                    phase_next      = PHASE_BODY;
                end
                else
                begin
                    phase_next = PHASE_LEN;
                end
            end
            PHASE_LEN:
            begin
                // length byte itself is not emitted
                bytes_left_next = POS_W'(rx_byte) + CRC_BYTES;
                next_pos_next   = POS_W'(1);
                phase_next      = PHASE_BODY;
            end
            PHASE_BODY:
            begin
                emit          = 1'b1;
                emit_pos      = next_pos_reg;
                emit_last     = fin;
                next_pos_next = next_pos_reg + POS_W'(1);
                if (fin)
                begin
                    bytes_left_next = '0;
                    phase_next      = PHASE_HDR1;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - POS_W'(1);
                end
            end
            default:
            begin
                // hunting, also unused codes
                phase_next = (rx_byte == header_first_reg) ? PHASE_HDR2 : PHASE_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_HDR1;
            bytes_left_reg <= '0;
            next_pos_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            next_pos_reg   <= next_pos_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            data_byte_reg <= rx_byte;
            position_reg  <= emit_pos;
            last_reg      <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign position  = position_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // a command byte always lands in the output as position zero
    a_cmd_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PHASE_CMD |=> out_valid && position == '0 && !last)
        else $error("command byte not emitted at position zero");

    // outside the body the byte counter is idle
    a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PHASE_BODY |-> bytes_left_reg == '0)
        else $error("bytes left nonzero outside body");

    // the closing byte is never the command byte
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> position != '0)
        else $error("last flag on position zero");
`endif

endmodule
